@@ src/sha_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;

  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // shift push_val into the block shift register
    logic sel_byte;    // 1: input byte, 0: pad byte value below
    logic [7:0] pad_val;
    logic count_byte;  // add one to the message length
    logic comp_start;  // load working variables from the hash
    logic comp_round;  // run one round
    logic comp_final;  // add working variables into the hash
    logic restart;     // back to initial hash, zero fill and length
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
    logic       round_last;
    logic [63:0] bits;
  } sha_stat_t;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int unsigned r);
    return (v >> r) | (v << (32 - r));
  endfunction

  function automatic word_t bsig0(word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t ssig0(word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage
`default_nettype wire

@@ src/sha_if.sv @@
// Valid/ready channel interfaces for the byte input and the digest output.
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

@@ src/sha_datapath.sv @@
// SHA-256 datapath: block shift register, schedule, round unit, hash and length.
`default_nettype none
module sha_datapath import sha_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sha_cmd_t  cmd,
  input  wire logic [7:0] in_byte,
  input  wire logic [1:0] out_sel,
  output sha_stat_t      stat,
  output logic [63:0]    out_word
);

  word_t       sched [16];
  word_t       wv [8];
  word_t       hash_words [8];
  logic [5:0]  fill_count;
  logic [60:0] byte_total;
  logic [5:0]  round;

  logic [7:0] push_val;
  word_t      wt, t1, t2, wnew;

  assign push_val = cmd.sel_byte ? in_byte : cmd.pad_val;

  // Schedule word for this round; the window shifts so sched[0] is W[t].
  always_comb begin
    wnew = ssig1(sched[14]) + sched[9] + ssig0(sched[1]) + sched[0];
    wt   = sched[0];
    t1   = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundK[round] + wt;
    t2   = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Fill count, message length and round counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill_count <= '0;
      byte_total <= '0;
    end else begin
      if (cmd.push) fill_count <= fill_count + 6'd1;
      if (cmd.count_byte) byte_total <= byte_total + 61'd1;
    end
    if (rst || cmd.comp_start) round <= '0;
    else if (cmd.comp_round) round <= round + 6'd1;
  end

  // Bytes shift into the schedule window, so after 64 bytes sched[0] holds the
  // first four bytes big-endian; during compression the window rolls.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
      sched[15] <= {sched[15][23:0], push_val};
    end else if (cmd.comp_round) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= wnew;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
    end else if (cmd.comp_round) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
    end
  end

  // Hash words.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= InitHash[i];
    end else if (cmd.comp_final) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + wv[i];
    end
  end

  assign out_word = {hash_words[{out_sel, 1'b0}], hash_words[{out_sel, 1'b1}]};

  assign stat.fill       = fill_count;
  assign stat.round      = round;
  assign stat.round_last = (round == 6'(Rounds - 1));
  assign stat.bits       = {byte_total, 3'b000};

endmodule
`default_nettype wire

@@ src/sha_ctrl.sv @@
// SHA-256 controller: input handshake, padding sequence, compression and output.
`default_nettype none
module sha_ctrl import sha_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  sha_in_if.sink         in_ch,
  sha_out_if.source      out_ch,
  input  wire sha_stat_t stat,
  input  wire logic [63:0] dp_word,
  output sha_cmd_t       cmd,
  output logic [1:0]     out_sel
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FINAL = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_LEN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic       ending, ending_next;   // message end pending
  logic       padded, padded_next;   // 0x80 already pushed
  logic [2:0] len_idx, len_idx_next;
  logic [1:0] widx, widx_next;
  logic       out_pending;           // the block being compressed is the last one
  logic       fire;

  assign fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word = dp_word;
  assign out_ch.word_index = widx;
  assign out_ch.last_word = (widx == 2'd3);
  assign out_sel = widx;

  // Next state and datapath commands.
  always_comb begin
    cmd = '0;
    state_next = state;
    ending_next = ending;
    padded_next = padded;
    len_idx_next = len_idx;
    widx_next = widx;
    unique case (state)
      S_IDLE: begin
        if (fire) begin
          if (in_ch.byte_present) begin
            cmd.push = 1'b1;
            cmd.sel_byte = 1'b1;
            cmd.count_byte = 1'b1;
          end
          ending_next = in_ch.end_of_message;
          padded_next = 1'b0;
          len_idx_next = '0;
          if (in_ch.byte_present && stat.fill == 6'd63) state_next = S_START;
          else if (in_ch.end_of_message) state_next = S_PAD;
        end
      end
      S_START: begin
        cmd.comp_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.comp_round = 1'b1;
        if (stat.round_last) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.comp_final = 1'b1;
        if (out_pending) state_next = S_OUT;
        else if (ending) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_PAD: begin
        cmd.push = 1'b1;
        cmd.pad_val = padded ? 8'h00 : PadByte;
        padded_next = 1'b1;
        if (stat.fill == 6'd55) state_next = S_LEN;
        else if (stat.fill == 6'd63) state_next = S_START;
      end
      S_LEN: begin
        cmd.push = 1'b1;
        cmd.pad_val = stat.bits[8*(7-len_idx) +: 8];
        len_idx_next = len_idx + 3'd1;
        if (len_idx == 3'd7) begin
          state_next = S_START;
          ending_next = 1'b0;
          widx_next = '0;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          widx_next = widx + 2'd1;
          if (widx == 2'd3) begin
            cmd.restart = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers; the last length byte marks the final compression.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ending <= 1'b0;
      padded <= 1'b0;
      len_idx <= '0;
      widx <= '0;
      out_pending <= 1'b0;
    end else begin
      state <= state_next;
      ending <= ending_next;
      padded <= padded_next;
      len_idx <= len_idx_next;
      widx <= widx_next;
      if (state == S_LEN && len_idx == 3'd7) out_pending <= 1'b1;
      else if (state == S_OUT) out_pending <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/sha256_byte_stream_hasher.sv @@
// SHA-256 byte stream hasher top level.
// Input: a byte is taken only while idle; no byte is taken while a full block is compressed.
// Compression: one round per cycle in the round state, between the start and final states.
// Message end: padding pushes one byte per cycle, one or two compressions, then four output words.
// Reset (rst, synchronous) restores the initial hash, zero fill and zero length.
`default_nettype none
module sha256_byte_stream_hasher import sha_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [63:0] dp_word;
  logic [1:0]  out_sel;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .stat(stat), .dp_word(dp_word), .cmd(cmd), .out_sel(out_sel)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_byte(in_ch.data_byte),
    .out_sel(out_sel), .stat(stat), .out_word(dp_word)
  );

`ifndef NO_ASSERTIONS
  // No input is taken while a digest is being delivered.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
  // The last word flag marks index three only.
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last_word |-> out_ch.word_index == 2'd3)
    else $error("last word at wrong index");
  // Restart after the last word leaves the block ready for input.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready)
    else $error("no return to idle after digest");
`endif

endmodule
`default_nettype wire
